### hw/rtl/round_robin_task_table_scheduler_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef ROUND_ROBIN_TASK_TABLE_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_TABLE_SCHEDULER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/rrts_pkg.sv
package rrts_pkg;

	localparam int TASK_SLOTS_DEF = 16;
	localparam int PID_W  = 16;
	localparam int PRI_W  = 8;
	localparam int SCR_W  = 8;
	localparam int PICK_W = 32;
	localparam int QNT_W  = 9;
	localparam int REQ_W  = 4;

	typedef enum logic [1:0] {
		ST_DEAD    = 2'd0,
		ST_ACTIVE  = 2'd1,
		ST_PAUSED  = 2'd2,
		ST_WAITING = 2'd3
	} slot_state_t;

	localparam logic [REQ_W-1:0] REQ_ADD       = 4'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE    = 4'd1;
	localparam logic [REQ_W-1:0] REQ_PAUSE     = 4'd2;
	localparam logic [REQ_W-1:0] REQ_SET_PRI   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SET_STATE = 4'd4;
	localparam logic [REQ_W-1:0] REQ_GET_STATE = 4'd5;
	localparam logic [REQ_W-1:0] REQ_TICK      = 4'd6;
	localparam logic [REQ_W-1:0] REQ_KILL_ALL  = 4'd7;
	localparam logic [REQ_W-1:0] REQ_SCREEN    = 4'd8;
	localparam logic [REQ_W-1:0] REQ_CHANGE    = 4'd9;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_IMMORTAL  = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	localparam logic [1:0] CFG_MAX_PRI  = 2'd0;
	localparam logic [1:0] CFG_DEF_PRI  = 2'd1;
	localparam logic [1:0] CFG_IDLE_PID = 2'd2;

	// Command broadcast to the row of slot cells; only the selected cell acts.
	typedef struct packed {
		logic              wr_state;
		slot_state_t       state;
		logic              add;
		logic [PID_W-1:0]  pid;
		logic [PRI_W-1:0]  pri;
		logic              imm;
		logic [SCR_W-1:0]  scr;
		logic              wr_pri;
		logic              inc_pick;
	} cell_cmd_t;

	// What a cell shows to the controller.
	typedef struct packed {
		slot_state_t       state;
		logic [PID_W-1:0]  pid;
		logic [PRI_W-1:0]  pri;
		logic              imm;
		logic [SCR_W-1:0]  scr;
	} cell_view_t;

endpackage

### hw/rtl/rrts_cell.sv
module rrts_cell
	import rrts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sel,
	input  cell_cmd_t  cmd,
	output cell_view_t view
);

	slot_state_t       state_q;
	logic [PID_W-1:0]  pid_q;
	logic [PRI_W-1:0]  pri_q;
	logic              imm_q;
	logic [SCR_W-1:0]  scr_q;
	logic [PICK_W-1:0] picks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DEAD;
		end else if (sel && cmd.add) begin
			state_q <= ST_ACTIVE;
		end else if (sel && cmd.wr_state) begin
			state_q <= cmd.state;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.add) begin
			pid_q   <= cmd.pid;
			pri_q   <= cmd.pri;
			imm_q   <= cmd.imm;
			scr_q   <= cmd.scr;
			picks_q <= PICK_W'(1);
		end else begin
			if (sel && cmd.wr_pri) begin
				pri_q <= cmd.pri;
			end
			if (sel && cmd.inc_pick) begin
				picks_q <= picks_q + 1'b1;
			end
		end
	end

	assign view = '{state: state_q, pid: pid_q, pri: pri_q, imm: imm_q, scr: scr_q};

endmodule

### hw/rtl/round_robin_task_table_scheduler_unit.sv
// Task-table scheduler: a row of TASK_SLOTS slot cells, each holding one task's state, pid,
// priority, immortal flag, screen and pick count, steered by one sequencer that visits the
// cells one slot per cycle. A request word is taken only while the sequencer is idle; the
// result word is held in an output register, so the next request may be taken while the
// previous result still waits. An add scans the row for a free slot, a pid request scans
// it for the pid, kill-all, screen toggle and change-state-where sweep the whole row, a
// tick that keeps its task bumps its pick count, and a tick that switches runs a
// round-robin scan, then an idle-task scan. Configuration registers take effect on the
// next request; they are to be written only while no request is in flight, a rule for
// the user that the block itself does not enforce.
module round_robin_task_table_scheduler_unit
	import rrts_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [REQ_W-1:0]         req_type,
	input  logic [PID_W-1:0]         target_pid,
	input  logic [PRI_W-1:0]         new_priority,
	input  logic signed [15:0]       priority_request,
	input  logic                     immortal_flag,
	input  logic [SCR_W-1:0]         screen_id,
	input  logic [1:0]               wanted_state,
	input  logic [1:0]               match_state,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [PID_W-1:0]         result_pid,
	output logic [1:0]               task_state,
	output logic [PID_W-1:0]         running_pid,
	output logic                     switched,
	output logic                     reschedule
);

	localparam int IW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam logic [IW-1:0] LAST  = IW'(TASK_SLOTS - 1);
	localparam logic [CW-1:0] SLOTS = CW'(TASK_SLOTS);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LOOK  = 8'b0000_0010,
		S_FREE  = 8'b0000_0100,
		S_SWEEP = 8'b0000_1000,
		S_TICK  = 8'b0001_0000,
		S_SRCH  = 8'b0010_0000,
		S_IDLK  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} fsm_t;

	fsm_t st_q, st_d;
	logic [IW-1:0] idx_q, idx_d, start_q, start_d, fslot_q, fslot_d, cur_q, cur_d;
	logic [CW-1:0] steps_q, steps_d, cnt_q, cnt_d, live_q, live_d;
	logic found_q, found_d;
	logic [PID_W-1:0] npid_q, npid_d;
	logic [QNT_W-1:0] qnt_q, qnt_d;
	logic [PRI_W-1:0] maxp_q, defp_q;
	logic [PID_W-1:0] idlep_q;

	// Latched request word.
	logic [REQ_W-1:0]   req_q;
	logic [PID_W-1:0]   tpid_q;
	logic [PRI_W-1:0]   npri_q;
	logic signed [15:0] preq_q;
	logic               imm_q;
	logic [SCR_W-1:0]   scr_q;
	slot_state_t        want_q, match_q;

	// Result being built.
	logic [1:0]       stat_q, stat_d, tst_q, tst_d;
	logic [PID_W-1:0] rpid_q, rpid_d;
	logic             sw_q, sw_d, rs_q, rs_d;

	logic             ovalid_q, load;
	logic [1:0]       ostat_q, otst_q;
	logic [PID_W-1:0] orpid_q, orun_q;
	logic             osw_q, ors_q;

	cell_cmd_t        cmd;
	logic [IW-1:0]    cmd_idx;
	cell_view_t       vw [TASK_SLOTS];
	cell_view_t       c, ccur, cnx;
	logic [IW-1:0]    idx_inc, nx;
	logic             accept;

	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		rrts_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.sel   (cmd_idx == IW'(g)),
			.cmd   (cmd),
			.view  (vw[g])
		);
	end

	assign in_ready = (st_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign idx_inc  = idx_q + 1'b1;
	assign nx       = (idx_q == LAST) ? '0 : idx_inc;
	assign c        = vw[idx_q];
	assign ccur     = vw[cur_q];
	assign cnx      = vw[nx];
	assign load     = (st_q == S_FIN) && (!ovalid_q || out_ready);

	always_comb begin
		st_d    = st_q;
		idx_d   = idx_q;
		start_d = start_q;
		fslot_d = fslot_q;
		cur_d   = cur_q;
		steps_d = steps_q;
		cnt_d   = cnt_q;
		live_d  = live_q;
		found_d = found_q;
		npid_d  = npid_q;
		qnt_d   = qnt_q;
		stat_d  = stat_q;
		tst_d   = tst_q;
		rpid_d  = rpid_q;
		sw_d    = sw_q;
		rs_d    = rs_q;
		cmd     = '0;
		cmd_idx = idx_q;

		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					stat_d = STAT_DONE;
					tst_d  = 2'd0;
					rpid_d = '0;
					sw_d   = 1'b0;
					rs_d   = 1'b0;
					idx_d  = '0;
					case (req_type)
						REQ_ADD: begin
							if (live_q >= SLOTS) begin
								stat_d = STAT_FULL;
								st_d   = S_FIN;
							end else begin
								st_d = S_FREE;
							end
						end
						REQ_REMOVE, REQ_PAUSE, REQ_SET_PRI, REQ_SET_STATE,
						REQ_GET_STATE: st_d = S_LOOK;
						REQ_TICK: st_d = S_TICK;
						REQ_KILL_ALL, REQ_SCREEN: st_d = S_SWEEP;
						REQ_CHANGE: st_d = (match_state == ST_DEAD) ? S_FIN : S_SWEEP;
						default: st_d = S_FIN;
					endcase
				end
			end

			S_LOOK: begin
				if (c.state != ST_DEAD && c.pid == tpid_q) begin
					st_d = S_FIN;
					case (req_q)
						REQ_REMOVE: begin
							if (c.imm) begin
								stat_d = STAT_IMMORTAL;
							end else begin
								cmd.wr_state = 1'b1;
								cmd.state    = ST_DEAD;
								if (live_q != '0) live_d = live_q - 1'b1;
								if (idx_q == cur_q) begin
									qnt_d = {1'b0, c.pri} + 1'b1;
									rs_d  = 1'b1;
								end
							end
						end
						REQ_PAUSE: begin
							if (c.imm) begin
								stat_d = STAT_IMMORTAL;
							end else begin
								cmd.wr_state = 1'b1;
								cmd.state    = (c.state == ST_PAUSED) ? ST_ACTIVE : ST_PAUSED;
								if (idx_q == cur_q) begin
									qnt_d = {1'b0, c.pri} + 1'b1;
									rs_d  = 1'b1;
								end
							end
						end
						REQ_SET_PRI: begin
							cmd.wr_pri = 1'b1;
							if (preq_q > $signed({8'h00, maxp_q})) begin
								cmd.pri = maxp_q;
							end else if (preq_q < 16'sd1) begin
								cmd.pri = defp_q;
							end else begin
								cmd.pri = preq_q[PRI_W-1:0];
							end
						end
						REQ_SET_STATE: begin
							cmd.wr_state = 1'b1;
							cmd.state    = want_q;
							if (want_q == ST_DEAD && live_q != '0) live_d = live_q - 1'b1;
						end
						REQ_GET_STATE: tst_d = c.state;
						default: ;
					endcase
				end else if (idx_q == LAST) begin
					stat_d = STAT_NOT_FOUND;
					st_d   = S_FIN;
				end else begin
					idx_d = idx_inc;
				end
			end

			S_FREE: begin
				if (c.state == ST_DEAD) begin
					cmd.add = 1'b1;
					cmd.pid = npid_q;
					cmd.pri = npri_q;
					cmd.imm = imm_q;
					cmd.scr = scr_q;
					live_d  = live_q + 1'b1;
					rpid_d  = npid_q;
					npid_d  = npid_q + 1'b1;
					st_d    = S_FIN;
				end else if (idx_q == LAST) begin
					stat_d = STAT_FULL;
					st_d   = S_FIN;
				end else begin
					idx_d = idx_inc;
				end
			end

			S_SWEEP: begin
				case (req_q)
					REQ_KILL_ALL: begin
						if (c.state != ST_DEAD && !c.imm) begin
							cmd.wr_state = 1'b1;
							cmd.state    = ST_DEAD;
							if (live_q != '0) live_d = live_q - 1'b1;
							if (idx_q == cur_q) begin
								qnt_d = {1'b0, c.pri} + 1'b1;
								rs_d  = 1'b1;
							end
						end
					end
					REQ_SCREEN: begin
						if (c.state != ST_DEAD && c.state != ST_WAITING && c.scr == scr_q) begin
							cmd.wr_state = 1'b1;
							cmd.state    = (c.state == ST_PAUSED) ? ST_ACTIVE : ST_PAUSED;
						end
					end
					default: begin
						if (c.state != ST_DEAD && c.state == match_q) begin
							cmd.wr_state = 1'b1;
							cmd.state    = want_q;
							if (want_q == ST_DEAD && live_q != '0) live_d = live_q - 1'b1;
						end
					end
				endcase
				if (idx_q == LAST) begin
					st_d = S_FIN;
				end else begin
					idx_d = idx_inc;
				end
			end

			S_TICK: begin
				cmd_idx = cur_q;
				if (ccur.state != ST_DEAD && ccur.pri >= PRI_W'(2) &&
						qnt_q < ({1'b0, ccur.pri} - 1'b1)) begin
					cmd.inc_pick = 1'b1;
					qnt_d        = qnt_q + 1'b1;
					st_d         = S_FIN;
				end else begin
					sw_d    = 1'b1;
					idx_d   = cur_q;
					start_d = cur_q;
					cnt_d   = '0;
					steps_d = '0;
					found_d = 1'b0;
					st_d    = S_SRCH;
				end
			end

			S_SRCH: begin
				cmd_idx = nx;
				if (cnt_q < live_q && steps_q < SLOTS) begin
					idx_d   = nx;
					steps_d = steps_q + 1'b1;
					if (cnx.state != ST_DEAD) cnt_d = cnt_q + 1'b1;
					if (cnx.state == ST_ACTIVE) begin
						cmd.inc_pick = 1'b1;
						if (cnx.pid == idlep_q) begin
							cur_d = nx;
							qnt_d = '0;
							st_d  = S_FIN;
						end else begin
							found_d = 1'b1;
							fslot_d = nx;
							idx_d   = '0;
							st_d    = S_IDLK;
						end
					end
				end else begin
					found_d = 1'b0;
					idx_d   = '0;
					st_d    = S_IDLK;
				end
			end

			S_IDLK: begin
				if (c.state != ST_DEAD && c.pid == idlep_q) begin
					cmd.wr_state = 1'b1;
					cmd.state    = found_q ? ST_PAUSED : ST_ACTIVE;
					cur_d        = found_q ? fslot_q : idx_q;
					qnt_d        = '0;
					st_d         = S_FIN;
				end else if (idx_q == LAST) begin
					cur_d = found_q ? fslot_q : start_q;
					qnt_d = '0;
					st_d  = S_FIN;
				end else begin
					idx_d = idx_inc;
				end
			end

			S_FIN: begin
				if (load) st_d = S_IDLE;
			end

			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			cur_q    <= '0;
			live_q   <= '0;
			npid_q   <= '0;
			qnt_q    <= '0;
			maxp_q   <= PRI_W'(10);
			defp_q   <= PRI_W'(1);
			idlep_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cur_q  <= cur_d;
			live_q <= live_d;
			npid_q <= npid_d;
			qnt_q  <= qnt_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_PRI:  maxp_q  <= cfg_wdata[PRI_W-1:0];
					CFG_DEF_PRI:  defp_q  <= cfg_wdata[PRI_W-1:0];
					CFG_IDLE_PID: idlep_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		start_q <= start_d;
		fslot_q <= fslot_d;
		steps_q <= steps_d;
		cnt_q   <= cnt_d;
		found_q <= found_d;
		stat_q  <= stat_d;
		tst_q   <= tst_d;
		rpid_q  <= rpid_d;
		sw_q    <= sw_d;
		rs_q    <= rs_d;
		if (accept) begin
			req_q   <= req_type;
			tpid_q  <= target_pid;
			npri_q  <= new_priority;
			preq_q  <= priority_request;
			imm_q   <= immortal_flag;
			scr_q   <= screen_id;
			want_q  <= slot_state_t'(wanted_state);
			match_q <= slot_state_t'(match_state);
		end
		if (load) begin
			ostat_q <= stat_q;
			orpid_q <= rpid_q;
			otst_q  <= tst_q;
			orun_q  <= (ccur.state != ST_DEAD) ? ccur.pid : '0;
			osw_q   <= sw_q;
			ors_q   <= rs_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign status      = ostat_q;
	assign result_pid  = orpid_q;
	assign task_state  = otst_q;
	assign running_pid = orun_q;
	assign switched    = osw_q;
	assign reschedule  = ors_q;

endmodule

### hw/rtl/rrts_chk.sv
`include "round_robin_task_table_scheduler_unit_macros.svh"

module rrts_chk
	import rrts_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       status,
	input logic [PID_W-1:0] result_pid,
	input logic             switched,
	input logic             reschedule
);

	// A result word that is not taken stays offered.
	`RRTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// The sequencer is busy in the cycle after it takes a request.
	`RRTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// Only a done result, such as a successful add, may carry a nonzero pid.
	`RRTS_ASSERT_NOW(a_pid_only_done, out_valid && status != STAT_DONE, result_pid == '0)
	// A tick never asks for another tick.
	`RRTS_ASSERT_NOW(a_tick_no_resched, out_valid && switched, !reschedule)

endmodule

bind round_robin_task_table_scheduler_unit rrts_chk u_rrts_chk (.*);

### tb/round_robin_task_table_scheduler_unit_tb.sv
`timescale 1ns / 100ps

module round_robin_task_table_scheduler_unit_tb;
	import rrts_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;
	// Slowest request: a switching tick scans the row twice.
	localparam int LATENCY = 2 * SLOTS + 4;
	localparam int SETTLE_CYCLES = LATENCY + 8;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1800;

	// One request word as it is offered on the input channel.
	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [PID_W-1:0]  pid;
		logic [PRI_W-1:0]  newpri;
		logic signed [15:0] preq;
		logic              imm;
		logic [SCR_W-1:0]  scr;
		logic [1:0]        want;
		logic [1:0]        match;
	} sched_req_t;

	// One result word as it should appear on the output channel.
	typedef struct {
		logic [1:0]        status;
		logic [PID_W-1:0]  rpid;
		logic [1:0]        tstate;
		logic [PID_W-1:0]  running;
		logic              switched;
		logic              resched;
	} sched_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = '0;
	logic [PID_W-1:0] target_pid = '0;
	logic [PRI_W-1:0] new_priority = '0;
	logic signed [15:0] priority_request = '0;
	logic immortal_flag = 1'b0;
	logic [SCR_W-1:0] screen_id = '0;
	logic [1:0] wanted_state = '0;
	logic [1:0] match_state = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [PID_W-1:0] result_pid;
	logic [1:0] task_state;
	logic [PID_W-1:0] running_pid;
	logic switched;
	logic reschedule;

	round_robin_task_table_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .target_pid(target_pid), .new_priority(new_priority),
		.priority_request(priority_request), .immortal_flag(immortal_flag),
		.screen_id(screen_id), .wanted_state(wanted_state), .match_state(match_state),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_pid(result_pid), .task_state(task_state),
		.running_pid(running_pid), .switched(switched), .reschedule(reschedule)
	);

	always #1 clk = ~clk;

	// The predictor keeps its own copy of the task table and the scheduler registers.
	slot_state_t      tbl_state [SLOTS];
	logic [PID_W-1:0] tbl_pid   [SLOTS];
	logic [PRI_W-1:0] tbl_pri   [SLOTS];
	logic             tbl_imm   [SLOTS];
	logic [SCR_W-1:0] tbl_scr   [SLOTS];
	logic [PICK_W-1:0] tbl_picks [SLOTS];
	int unsigned      cur_slot;
	int unsigned      live_tasks;
	logic [PID_W-1:0] pid_counter;
	logic [QNT_W-1:0] quantum;
	logic [PRI_W-1:0] max_pri_reg;
	logic [PRI_W-1:0] def_pri_reg;
	logic [PID_W-1:0] idle_pid_reg;

	sched_rsp_t pending_rsp[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cfg_writes = 0;
	// When set, neither side idles between words.
	bit no_idle = 1'b0;
	// The test bumps this to ask the receiver for one long hold-off.
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int stall_left = 0;

	// A pid names the lowest live slot that holds it.
	function automatic int find_pid(logic [PID_W-1:0] pid);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_state[i] != ST_DEAD && tbl_pid[i] == pid)
				return i;
		return -1;
	endfunction

	function automatic void kill_slot(int s);
		tbl_state[s] = ST_DEAD;
		if (live_tasks > 0)
			live_tasks--;
	endfunction

	// Ending or pausing the running task spends its quantum so that the next tick switches.
	function automatic void spend_quantum();
		quantum = QNT_W'({1'b0, tbl_pri[cur_slot]} + 9'd1);
	endfunction

	function automatic void put_state(int s, logic [1:0] st);
		if (st == ST_DEAD)
			kill_slot(s);
		else
			tbl_state[s] = slot_state_t'(st);
	endfunction

	// Returns 1 when the tick ran the round-robin search.
	function automatic bit run_tick();
		int unsigned cur, start, seen, steps;
		int idle_at;
		bit found;
		cur = cur_slot;
		if (tbl_state[cur] != ST_DEAD) begin
			if (tbl_pri[cur] >= 2 && int'(quantum) < int'(tbl_pri[cur]) - 1) begin
				tbl_picks[cur]++;
				quantum++;
				return 1'b0;
			end
		end
		start = cur;
		seen = 0;
		steps = 0;
		found = 1'b0;
		while (!found && seen < live_tasks && steps < SLOTS) begin
			cur = (cur + 1) % SLOTS;
			steps++;
			if (tbl_state[cur] != ST_DEAD)
				seen++;
			if (tbl_state[cur] == ST_ACTIVE) begin
				found = 1'b1;
				tbl_picks[cur]++;
			end
		end
		if (!found) begin
			// Nothing is runnable: fall back on the idle task, if the table holds one.
			idle_at = find_pid(idle_pid_reg);
			if (idle_at >= 0) begin
				cur = idle_at;
				tbl_state[cur] = ST_ACTIVE;
			end else begin
				cur = start;
			end
		end else if (tbl_pid[cur] != idle_pid_reg) begin
			idle_at = find_pid(idle_pid_reg);
			if (idle_at >= 0)
				tbl_state[idle_at] = ST_PAUSED;
		end
		cur_slot = cur;
		quantum = '0;
		return 1'b1;
	endfunction

	// Works out the result word of one request and moves the table on.
	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t o;
		int pos;
		int s;
		bit hit;
		o = '{default: '0};
		pos = -1;
		if (r.req >= REQ_REMOVE && r.req <= REQ_GET_STATE) begin
			pos = find_pid(r.pid);
			if (pos < 0)
				o.status = STAT_NOT_FOUND;
		end
		case (r.req)
			REQ_ADD: begin
				s = 0;
				while (s < SLOTS && tbl_state[s] != ST_DEAD)
					s++;
				if (live_tasks >= SLOTS || s >= SLOTS) begin
					o.status = STAT_FULL;
				end else begin
					live_tasks++;
					tbl_pid[s] = pid_counter;
					o.rpid = pid_counter;
					pid_counter++;
					tbl_state[s] = ST_ACTIVE;
					tbl_pri[s] = r.newpri;
					tbl_imm[s] = r.imm;
					tbl_scr[s] = r.scr;
					tbl_picks[s] = 1;
				end
			end
			REQ_REMOVE, REQ_PAUSE: begin
				if (pos >= 0) begin
					if (tbl_imm[pos]) begin
						o.status = STAT_IMMORTAL;
					end else begin
						if (r.req == REQ_REMOVE)
							kill_slot(pos);
						else
							tbl_state[pos] = (tbl_state[pos] == ST_PAUSED) ? ST_ACTIVE : ST_PAUSED;
						if (pos == int'(cur_slot)) begin
							spend_quantum();
							o.resched = 1'b1;
						end
					end
				end
			end
			REQ_SET_PRI: begin
				if (pos >= 0) begin
					if (int'(r.preq) > int'(max_pri_reg))
						tbl_pri[pos] = max_pri_reg;
					else if (int'(r.preq) < 1)
						tbl_pri[pos] = def_pri_reg;
					else
						tbl_pri[pos] = r.preq[PRI_W-1:0];
				end
			end
			REQ_SET_STATE: begin
				if (pos >= 0)
					put_state(pos, r.want);
			end
			REQ_GET_STATE: begin
				if (pos >= 0)
					o.tstate = tbl_state[pos];
			end
			REQ_TICK: o.switched = run_tick();
			REQ_KILL_ALL: begin
				hit = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] != ST_DEAD && !tbl_imm[i]) begin
						kill_slot(i);
						if (i == int'(cur_slot))
							hit = 1'b1;
					end
				end
				if (hit) begin
					spend_quantum();
					o.resched = 1'b1;
				end
			end
			REQ_SCREEN: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_state[i] != ST_DEAD && tbl_state[i] != ST_WAITING
							&& tbl_scr[i] == r.scr)
						tbl_state[i] = (tbl_state[i] == ST_PAUSED) ? ST_ACTIVE : ST_PAUSED;
			end
			REQ_CHANGE: begin
				if (r.match != ST_DEAD)
					for (int i = 0; i < SLOTS; i++)
						if (tbl_state[i] != ST_DEAD && tbl_state[i] == r.match)
							put_state(i, r.want);
			end
			default: ;
		endcase
		o.running = (tbl_state[cur_slot] != ST_DEAD) ? tbl_pid[cur_slot] : '0;
		return o;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("result %0d: %s is %0h, expected %0h", words_checked, field, got, want);
		errors++;
	endtask

	// Offers one request word, waits for it to be taken, and files its expected result.
	// It is entered and left on a rising edge, so valid gets one assignment per step.
	task automatic send_word(sched_req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.req;
		target_pid <= r.pid;
		new_priority <= r.newpri;
		priority_request <= r.preq;
		immortal_flag <= r.imm;
		screen_id <= r.scr;
		wanted_state <= r.want;
		match_state <= r.match;
		do
			@(posedge clk);
		while (!in_ready);
		pending_rsp.push_back(schedule_step(r));
		words_sent++;
	endtask

	function automatic sched_req_t blank_word(logic [REQ_W-1:0] req);
		sched_req_t r;
		r.req = req;
		r.pid = PID_W'($urandom);
		r.newpri = PRI_W'($urandom);
		r.preq = 16'($urandom);
		r.imm = 1'($urandom);
		r.scr = SCR_W'($urandom);
		r.want = 2'($urandom);
		r.match = 2'($urandom);
		return r;
	endfunction

	// Mostly the pid of a live task, so that lookups succeed; sometimes any pid at all.
	function automatic logic [PID_W-1:0] live_pid();
		int s;
		if ($urandom_range(0, 4) != 0)
			for (int tries = 0; tries < 8; tries++) begin
				s = $urandom_range(0, SLOTS - 1);
				if (tbl_state[s] != ST_DEAD)
					return tbl_pid[s];
			end
		return PID_W'($urandom);
	endfunction

	// Waits until every result is back and the sequencer has surely gone idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAX_PRI: max_pri_reg = value[PRI_W-1:0];
			CFG_DEF_PRI: def_pri_reg = value[PRI_W-1:0];
			CFG_IDLE_PID: idle_pid_reg = value;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_regs(logic [7:0] maxp, logic [7:0] defp, logic [15:0] idle);
		drain();
		write_reg(CFG_MAX_PRI, {8'h00, maxp});
		write_reg(CFG_DEF_PRI, {8'h00, defp});
		write_reg(CFG_IDLE_PID, idle);
		@(posedge clk);
	endtask

	task automatic add_task(logic [7:0] pri, logic imm, logic [7:0] scr);
		sched_req_t r;
		r = blank_word(REQ_ADD);
		r.newpri = pri;
		r.imm = imm;
		r.scr = scr;
		send_word(r);
	endtask

	task automatic pid_word(logic [REQ_W-1:0] req, logic [15:0] pid);
		sched_req_t r;
		r = blank_word(req);
		r.pid = pid;
		send_word(r);
	endtask

	function automatic logic [15:0] running_pid_guess();
		return (tbl_state[cur_slot] != ST_DEAD) ? tbl_pid[cur_slot] : 16'd0;
	endfunction

	// Directed walk: field extremes, every request code and the corner cases of the table.
	task automatic test_directed();
		sched_req_t r;
		set_regs(8'd10, 8'd1, 16'd0);
		pid_word(REQ_TICK, 16'd0);          // empty table, no idle task: nothing moves
		add_task(8'd0, 1'b1, 8'd0);         // pid 0 is also the idle task; immortal
		add_task(8'd255, 1'b0, 8'd255);
		add_task(8'd3, 1'b0, 8'd255);
		pid_word(REQ_TICK, 16'd0);
		pid_word(REQ_TICK, 16'd0);
		pid_word(REQ_REMOVE, 16'd0);        // immortal, so refused
		pid_word(REQ_PAUSE, 16'd0);
		pid_word(REQ_REMOVE, 16'hffff);     // no such pid
		r = blank_word(REQ_SET_PRI); r.pid = 16'd2; r.preq = -16'sd32768; send_word(r);
		r = blank_word(REQ_SET_PRI); r.pid = 16'd2; r.preq = 16'sd0; send_word(r);
		r = blank_word(REQ_SET_PRI); r.pid = 16'd2; r.preq = 16'sd32767; send_word(r);
		r = blank_word(REQ_SET_PRI); r.pid = 16'd1; r.preq = 16'sd5; send_word(r);
		pid_word(REQ_PAUSE, running_pid_guess());  // pausing the running task
		pid_word(REQ_TICK, 16'd0);
		r = blank_word(REQ_SET_STATE); r.pid = 16'd1; r.want = ST_WAITING; send_word(r);
		pid_word(REQ_GET_STATE, 16'd1);
		r = blank_word(REQ_SCREEN); r.scr = 8'd255; send_word(r);
		r = blank_word(REQ_CHANGE); r.match = ST_DEAD; r.want = ST_ACTIVE; send_word(r);
		r = blank_word(REQ_CHANGE); r.match = ST_WAITING; r.want = ST_ACTIVE; send_word(r);
		r = blank_word(REQ_SET_STATE); r.pid = 16'd2; r.want = ST_DEAD; send_word(r);
		pid_word(REQ_KILL_ALL, 16'd0);
		pid_word(REQ_TICK, 16'd0);
		pid_word(4'd15, 16'd0);             // unused code: no change
		pid_word(REQ_GET_STATE, 16'd0);
	endtask

	// Fills every free slot, then asks for more: the table-full status.
	task automatic test_table_full();
		set_regs(8'd255, 8'd255, 16'hffff);
		pid_word(REQ_KILL_ALL, 16'd0);
		for (int i = 0; i < SLOTS + 2; i++)
			add_task(PRI_W'($urandom), 1'b0, SCR_W'($urandom_range(0, 3)));
		repeat (6) pid_word(REQ_TICK, 16'd0);
		pid_word(REQ_KILL_ALL, 16'd0);
	endtask

	function automatic sched_req_t random_word();
		sched_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) r = blank_word(REQ_ADD);
		else if (pick < 45) r = blank_word(REQ_TICK);
		else if (pick < 52) r = blank_word(REQ_REMOVE);
		else if (pick < 60) r = blank_word(REQ_PAUSE);
		else if (pick < 67) r = blank_word(REQ_SET_PRI);
		else if (pick < 73) r = blank_word(REQ_SET_STATE);
		else if (pick < 79) r = blank_word(REQ_GET_STATE);
		else if (pick < 81) r = blank_word(REQ_KILL_ALL);
		else if (pick < 87) r = blank_word(REQ_SCREEN);
		else if (pick < 93) r = blank_word(REQ_CHANGE);
		else r = blank_word(REQ_W'($urandom));
		r.pid = live_pid();
		// Few screens, so that a screen toggle usually hits something.
		if ($urandom_range(0, 3) != 0)
			r.scr = SCR_W'($urandom_range(0, 3));
		// Mostly small priorities keep quanta short; the rest span the whole range.
		if ($urandom_range(0, 3) != 0) begin
			r.newpri = PRI_W'($urandom_range(0, 6));
			r.preq = 16'(int'($urandom_range(0, 12)) - 2);
		end
		if ($urandom_range(0, 3) != 0)
			r.imm = 1'b0;
		return r;
	endfunction

	// Random traffic in phases, each with its own register setting and idling mode.
	task automatic test_random();
		int phase;
		phase = 0;
		while (words_sent + 150 < RANDOM_ITEMS) begin
			case (phase % 4)
				0: set_regs(8'd255, 8'd255, live_pid());
				1: set_regs(8'd1, 8'd1, live_pid());
				2: set_regs(8'd10, 8'd1, 16'd0);
				default: set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
					live_pid());
			endcase
			no_idle = (phase % 3 == 2);
			repeat (150) send_word(random_word());
			phase++;
		end
		no_idle = 1'b0;
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the
	// held result word blocks the sequencer and the input stalls.
	task automatic test_backpressure();
		drain();
		hold_asked++;
		repeat (20) send_word(random_word());
	endtask

	// Receiver: a random stall before each result word, or a long hold-off on request.
	always @(posedge clk) begin
		int gap;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_asked != hold_taken) begin
				hold_taken <= hold_asked;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				gap = no_idle ? 0 : $urandom_range(0, 4);
				stall_left <= gap;
				out_ready <= (gap == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Each taken result word is compared with the oldest expectation.
	always @(posedge clk) begin
		sched_rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("result word %0d arrived with nothing expected", words_checked);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (status !== want.status)
					report("status", 32'(status), 32'(want.status));
				if (result_pid !== want.rpid)
					report("result_pid", 32'(result_pid), 32'(want.rpid));
				if (task_state !== want.tstate)
					report("task_state", 32'(task_state), 32'(want.tstate));
				if (running_pid !== want.running)
					report("running_pid", 32'(running_pid), 32'(want.running));
				if (switched !== want.switched)
					report("switched", 32'(switched), 32'(want.switched));
				if (reschedule !== want.resched)
					report("reschedule", 32'(reschedule), 32'(want.resched));
			end
			words_checked++;
		end
	end

	// Watchdog: too long without any word moving on either channel ends the run.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("round_robin_task_table_scheduler_unit: mismatch");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = ST_DEAD;
			tbl_pid[i] = '0;
			tbl_pri[i] = '0;
			tbl_imm[i] = 1'b0;
			tbl_scr[i] = '0;
			tbl_picks[i] = '0;
		end
		cur_slot = 0;
		live_tasks = 0;
		pid_counter = '0;
		quantum = '0;
		max_pri_reg = 8'd10;
		def_pri_reg = 8'd1;
		idle_pid_reg = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random();
		test_backpressure();
		drain();
		$display("sent %0d request words, checked %0d result words, %0d register writes",
			words_sent, words_checked, cfg_writes);
		$display("covered all request codes, a full table, idle fallback and a long stall");
		if (errors == 0 && pending_rsp.size() == 0)
			$display("round_robin_task_table_scheduler_unit: match");
		else
			$display("round_robin_task_table_scheduler_unit: mismatch");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_cell.sv
hw/rtl/round_robin_task_table_scheduler_unit.sv
hw/rtl/rrts_chk.sv
tb/round_robin_task_table_scheduler_unit_tb.sv
